>>> hdl/tcgw_pkg.sv
// Shared types and constants for the text console glyph writer.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package tcgw_pkg;

    // Character codes with a meaning of their own.
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] FIRST_CODE     = 8'd32;

    // Cursor geometry.
    localparam int CELL      = 8;
    localparam int LINE_STEP = 10;

    // Configuration register indexes.
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_SCREEN_WIDTH  = 2'd0;
    localparam t_reg_idx REG_SCREEN_HEIGHT = 2'd1;
    localparam t_reg_idx REG_TEXT_COLOR    = 2'd2;
    localparam t_reg_idx REG_ERASE_COLOR   = 2'd3;

    // Configuration reset values.
    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd800;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd600;
    localparam logic [23:0] RST_TEXT_COLOR    = 24'hFFFFFF;
    localparam logic [23:0] RST_ERASE_COLOR   = 24'h000080;

    // Kind of the word being worked on.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_LOAD      = 3'd0;
    localparam t_kind KIND_NEWLINE   = 3'd1;
    localparam t_kind KIND_BACKSPACE = 3'd2;
    localparam t_kind KIND_GLYPH     = 3'd3;
    localparam t_kind KIND_BLANK     = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic load_write;
        logic newline;
        logic back_step;
        logic advance;
        logic clear_pos;
        logic scan_step;
        logic flush;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind kind;
        logic  emit;
        logic  pend_valid;
        logic  out_free;
        logic  scan_last;
        logic  row_end;
    } t_status;

endpackage

>>> hdl/tcgw_ctrl.sv
// Controller state machine of the text console glyph writer.
// Depends on tcgw_pkg; drives the datapath through t_cmd and reads t_status.
`timescale 1ns / 1ps

module tcgw_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tcgw_pkg::t_status i_sts,
    output tcgw_pkg::t_cmd   o_cmd
);
    import tcgw_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FLUSH  = 3'd4;
    localparam logic [2:0] ST_ADV    = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_step_ok;

    // A scan step would overwrite an unread output word only when a pixel is
    // found while one is already pending and the output is still full.
    assign w_step_ok = !(i_sts.emit && i_sts.pend_valid && !i_sts.out_free);

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_item = 1'b1;
                    n_state          = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_sts.kind)
                    KIND_LOAD: begin
                        o_cmd.load_write = 1'b1;
                        n_state          = ST_IDLE;
                    end
                    KIND_NEWLINE: begin
                        o_cmd.newline = 1'b1;
                        n_state       = ST_IDLE;
                    end
                    KIND_BACKSPACE: begin
                        o_cmd.back_step = 1'b1;
                        o_cmd.clear_pos = 1'b1;
                        n_state         = ST_SCAN;
                    end
                    KIND_GLYPH: begin
                        o_cmd.clear_pos = 1'b1;
                        n_state         = ST_FETCH;
                    end
                    default: begin
                        n_state = ST_ADV;
                    end
                endcase
            end
            ST_FETCH: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_step_ok) begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = ST_FLUSH;
                    end else if (i_sts.row_end && i_sts.kind == KIND_GLYPH) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = (i_sts.kind == KIND_BACKSPACE) ? ST_IDLE : ST_ADV;
                end
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/tcgw_dpath.sv
// Datapath of the text console glyph writer: configuration, cursor, glyph
// memory, cell scan counter, pending pixel and output register. Uses tcgw_pkg.
`timescale 1ns / 1ps

module tcgw_dpath #(
    parameter int GLYPH_COUNT = 96,
    parameter int COORD_BITS  = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  i_cfg_we,
    input  tcgw_pkg::t_reg_idx    i_cfg_index,
    input  logic [23:0]           i_cfg_data,
    // input word fields
    input  logic                  i_func,
    input  logic [7:0]            i_char_code,
    input  logic [6:0]            i_glyph_index,
    input  logic [2:0]            i_glyph_row,
    input  logic [7:0]            i_row_bits,
    // control
    input  tcgw_pkg::t_cmd        i_cmd,
    output tcgw_pkg::t_status     o_sts,
    // output word
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic [23:0]           o_pixel_color,
    output logic                  o_last_pixel
);
    import tcgw_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * 8;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CB    = COORD_BITS;
    localparam int CW    = (CB + 1 > 13) ? CB + 1 : 13;
    localparam logic [CB-1:0] COORD_MAX = {CB{1'b1}};

    // Configuration registers.
    logic [12:0] r_screen_width;
    logic [12:0] r_screen_height;
    logic [23:0] r_text_color;
    logic [23:0] r_erase_color;

    // Latched input word.
    logic        r_func;
    logic [7:0]  r_char_code;
    logic [6:0]  r_glyph_index;
    logic [2:0]  r_glyph_row;
    logic [7:0]  r_row_bits;

    // Cursor and scan position.
    logic [CB-1:0] r_col;
    logic [CB-1:0] r_row;
    logic [5:0]    r_pos;

    // Glyph memory and its registered read.
    logic [7:0] r_glyph_mem [DEPTH];
    logic [7:0] r_rd_data;

    // Pending pixel, held until the next one shows whether it is the last.
    logic          r_pend_valid;
    logic [CB-1:0] r_pend_x;
    logic [CB-1:0] r_pend_y;
    logic [23:0]   r_pend_color;

    // Output register.
    logic          r_out_valid;
    logic [CB-1:0] r_out_x;
    logic [CB-1:0] r_out_y;
    logic [23:0]   r_out_color;
    logic          r_out_last;

    logic [7:0]    w_glyph_num;
    logic          w_has_glyph;
    t_kind         w_kind;
    logic [2:0]    w_fx;
    logic [2:0]    w_fy;
    logic [CB:0]   w_x;
    logic [CB:0]   w_y;
    logic          w_bit_set;
    logic          w_in_screen;
    logic          w_emit;
    logic          w_out_free;
    logic          w_push;
    logic [CB:0]   w_row_step;
    logic [CB-1:0] w_row_next;
    logic [CB:0]   w_col_step;
    logic          w_wrap;

    // Decode of the latched word.
    assign w_glyph_num = r_char_code - FIRST_CODE;
    assign w_has_glyph = (r_char_code >= FIRST_CODE) &&
                         ({1'b0, w_glyph_num} < 9'(GLYPH_COUNT));

    always_comb begin
        priority if (r_func) begin
            w_kind = KIND_LOAD;
        end else if (r_char_code == CODE_NEWLINE) begin
            w_kind = KIND_NEWLINE;
        end else if (r_char_code == CODE_BACKSPACE) begin
            w_kind = KIND_BACKSPACE;
        end else if (w_has_glyph) begin
            w_kind = KIND_GLYPH;
        end else begin
            w_kind = KIND_BLANK;
        end
    end

    // Candidate pixel at the current scan position.
    assign w_fx        = r_pos[2:0];
    assign w_fy        = r_pos[5:3];
    assign w_x         = {1'b0, r_col} + (CB + 1)'(w_fx);
    assign w_y         = {1'b0, r_row} + (CB + 1)'(w_fy);
    assign w_bit_set   = (w_kind == KIND_BACKSPACE) ? 1'b1 : r_rd_data[~w_fx];
    assign w_in_screen = !w_x[CB] && !w_y[CB] &&
                         (CW'(w_x) < CW'(r_screen_width)) &&
                         (CW'(w_y) < CW'(r_screen_height));
    assign w_emit      = w_bit_set && w_in_screen;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_push     = r_pend_valid &&
                        ((i_cmd.scan_step && w_emit) || i_cmd.flush);

    // Status back to the controller.
    assign o_sts.kind       = w_kind;
    assign o_sts.emit       = w_emit;
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = w_out_free;
    assign o_sts.scan_last  = (r_pos == 6'h3F);
    assign o_sts.row_end    = (w_fx == 3'd7);

    // Cursor arithmetic: line step saturates, advance wraps at the screen edge.
    assign w_row_step = {1'b0, r_row} + (CB + 1)'(LINE_STEP);
    assign w_row_next = w_row_step[CB] ? COORD_MAX : w_row_step[CB-1:0];
    assign w_col_step = {1'b0, r_col} + (CB + 1)'(CELL);
    assign w_wrap     = w_col_step[CB] || (CW'(w_col_step) >= CW'(r_screen_width));

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_text_color    <= RST_TEXT_COLOR;
            r_erase_color   <= RST_ERASE_COLOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[12:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[12:0];
                REG_TEXT_COLOR:    r_text_color    <= i_cfg_data;
                REG_ERASE_COLOR:   r_erase_color   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_item) begin
            r_func        <= i_func;
            r_char_code   <= i_char_code;
            r_glyph_index <= i_glyph_index;
            r_glyph_row   <= i_glyph_row;
            r_row_bits    <= i_row_bits;
        end
    end

    // Glyph memory: one row write per load, one row read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_write && ({1'b0, r_glyph_index} < 8'(GLYPH_COUNT))) begin
            r_glyph_mem[AW'({r_glyph_index, r_glyph_row})] <= r_row_bits;
        end
        r_rd_data <= r_glyph_mem[AW'({w_glyph_num, w_fy})];
    end

    // Cursor update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.newline) begin
            r_col <= '0;
            r_row <= w_row_next;
        end else if (i_cmd.back_step) begin
            if (r_col >= CB'(CELL)) begin
                r_col <= r_col - CB'(CELL);
            end
        end else if (i_cmd.advance) begin
            if (w_wrap) begin
                r_col <= '0;
                r_row <= w_row_next;
            end else begin
                r_col <= w_col_step[CB-1:0];
            end
        end
    end

    // Scan position over the 8x8 cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.clear_pos) begin
            r_pos <= '0;
        end else if (i_cmd.scan_step) begin
            r_pos <= r_pos + 6'd1;
        end
    end

    // Pending pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.scan_step && w_emit) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.flush) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_emit) begin
            r_pend_x     <= w_x[CB-1:0];
            r_pend_y     <= w_y[CB-1:0];
            r_pend_color <= (w_kind == KIND_BACKSPACE) ? r_erase_color : r_text_color;
        end
    end

    // Output register; a flushed word is the last of its character.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_x     <= r_pend_x;
            r_out_y     <= r_pend_y;
            r_out_color <= r_pend_color;
            r_out_last  <= i_cmd.flush;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

>>> hdl/text_console_glyph_writer.sv
// Top level of the text console glyph writer: streaming ports and assertions.
// Instantiates tcgw_ctrl and tcgw_dpath; uses tcgw_pkg.
//
// Usage: the slave stream carries one command word per transfer. tuser is
// func (0 prints char_code, 1 loads one glyph row). A printed character
// becomes a run of pixel writes on the master stream, tlast on the final
// write; newline, loads, blank glyphs and fully clipped boxes give none.
// The configuration port writes screen width, screen height, text color
// and erase color; write it only while the block is idle.
// Flow: a word is taken only while the block is idle. A load or newline
// passes accept and decode; a backspace accept, decode (cursor step back),
// a scan of every cell pixel and flush; a drawable code accept, decode, a
// glyph memory fetch before each glyph row, a scan of the row's pixels,
// flush and cursor advance; a code without glyph accept, decode and cursor
// advance. Each found pixel waits in a holding register until the next one
// is found or the cell ends, so the first write leaves later when the first
// set bits are far apart.
// When the receiver stalls, the scan halts at the next found pixel and
// resumes once the output register drains; nothing is lost.
// Reset restores the cursor, the configuration and the handshake state; the
// glyph memory keeps no reset and must be loaded before use.
`timescale 1ns / 1ps

module text_console_glyph_writer #(
    parameter int GLYPH_COUNT = 96,
    parameter int COORD_BITS  = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // char_code[7:0], glyph_index[14:8], glyph_row[17:15], row_bits[25:18]
    input  logic [31:0]                    s_axis_tdata,
    // func[0]
    input  logic                           s_axis_tuser,
    // pixel stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x, pixel_y, pixel_color (24 bits), zero fill to whole bytes
    output logic [((2*COORD_BITS+31)/8)*8-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    // configuration port
    input  logic                           i_cfg_we,
    input  tcgw_pkg::t_reg_idx             i_cfg_index,
    input  logic [23:0]                    i_cfg_data
);
    import tcgw_pkg::*;

    localparam int OUT_W = ((2 * COORD_BITS + 31) / 8) * 8;

    t_cmd                  w_cmd;
    t_status               w_sts;
    logic [COORD_BITS-1:0] w_pixel_x;
    logic [COORD_BITS-1:0] w_pixel_y;
    logic [23:0]           w_pixel_color;

    // Controller.
    tcgw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    tcgw_dpath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_func        (s_axis_tuser),
        .i_char_code   (s_axis_tdata[7:0]),
        .i_glyph_index (s_axis_tdata[14:8]),
        .i_glyph_row   (s_axis_tdata[17:15]),
        .i_row_bits    (s_axis_tdata[25:18]),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_pixel_x     (w_pixel_x),
        .o_pixel_y     (w_pixel_y),
        .o_pixel_color (w_pixel_color),
        .o_last_pixel  (m_axis_tlast)
    );

    // Output word packing, lowest field first.
    assign m_axis_tdata = OUT_W'({w_pixel_color, w_pixel_y, w_pixel_x});

    // An idle block holds no pixel that still waits for its successor.
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.pend_valid)
        else $error("idle with a pending pixel");

    // A found pixel never displaces the pending one into a full output.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.scan_step && w_sts.emit && w_sts.pend_valid) |-> w_sts.out_free)
        else $error("output word overwritten");

    // A stalled pixel word stays unchanged until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("pixel word changed while stalled");

    // The block is not ready again in the cycle right after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready right after accept");

endmodule
